// ----- hdl/de_mutate_crossover_element_defines.svh -----
// Assertion macros shared by the differential evolution crossover element.
`ifndef DE_MUTATE_CROSSOVER_ELEMENT_DEFINES_SVH
`define DE_MUTATE_CROSSOVER_ELEMENT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the cycle after the antecedent.
`define DMX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crossover element: next-cycle check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define DMX_ASSERT_DELAY(lbl, ante, n, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
        else $error("crossover element: delayed check failed");

`else

`define DMX_ASSERT_NEXT(lbl, ante, cons)
`define DMX_ASSERT_DELAY(lbl, ante, n, cons)

`endif

`endif

// ----- hdl/demx_pkg.sv -----
// Shared types and constants of the differential evolution crossover element.
package demx_pkg;

    localparam int unsigned MAX_ELEMENTS = 1024;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned SCALE_W = 18;
    localparam int unsigned RATE_W  = 17;
    localparam int unsigned DRAW_W  = 16;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STRATEGY = 3'd0,
        REG_SCALE    = 3'd1,
        REG_RATE     = 3'd2,
        REG_LOWER    = 3'd3,
        REG_UPPER    = 3'd4
    } cfg_idx_t;

    typedef enum logic [1:0] {
        MODE_RAND1 = 2'd0,
        MODE_RAND2 = 2'd1,
        MODE_BEST1 = 2'd2
    } mode_t;

    localparam logic [1:0]         RESET_STRATEGY = MODE_RAND1;
    localparam logic [SCALE_W-1:0] RESET_SCALE    = 18'd32768;
    localparam logic [RATE_W-1:0]  RESET_RATE     = 17'd58982;
    localparam logic [VALUE_W-1:0] RESET_LOWER    = 32'hFFFF_0000;
    localparam logic [VALUE_W-1:0] RESET_UPPER    = 32'h0001_0000;

    typedef struct packed {
        logic [1:0]                strategy_mode;
        logic [SCALE_W-1:0]        scale_factor;
        logic [RATE_W-1:0]         crossover_rate;
        logic signed [VALUE_W-1:0] lower_bound;
        logic signed [VALUE_W-1:0] upper_bound;
    } cfg_t;

endpackage

// ----- hdl/demx_cfg_regs.sv -----
// Configuration register file of the differential evolution crossover element.
module demx_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [demx_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [demx_pkg::VALUE_W-1:0]        cfg_data,
    output demx_pkg::cfg_t                      cfg
);
    import demx_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Bits above a register's width are dropped; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_STRATEGY: cfg_next.strategy_mode  = cfg_data[1:0];
                REG_SCALE:    cfg_next.scale_factor   = cfg_data[SCALE_W-1:0];
                REG_RATE:     cfg_next.crossover_rate = cfg_data[RATE_W-1:0];
                REG_LOWER:    cfg_next.lower_bound    = cfg_data;
                REG_UPPER:    cfg_next.upper_bound    = cfg_data;
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.strategy_mode  <= RESET_STRATEGY;
            cfg_reg.scale_factor   <= RESET_SCALE;
            cfg_reg.crossover_rate <= RESET_RATE;
            cfg_reg.lower_bound    <= RESET_LOWER;
            cfg_reg.upper_bound    <= RESET_UPPER;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/de_mutate_crossover_element.sv -----
// Top level of the differential evolution mutation, crossover and repair element.
//
// This block forms one element of a differential evolution trial vector per
// transfer. It takes one item in every clock cycle: busy is always low, and an
// item is taken at each rising edge where start is high. The result of that item
// appears on the result ports, with done high for exactly one cycle; the
// receiver cannot stall, and results leave in the order items came. The item
// passes four register stages: the difference sums, bound distances and
// crossover decision, the three multipliers (scale factor times difference,
// repair draw times both bound distances), the mutant sum with the lower-bound
// repair, and the upper-bound repair into the output register. Values are signed
// Q16.16; every product is floored after the division by 65536. Write the
// configuration registers only while no item is in flight.
module de_mutate_crossover_element (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,

    input  logic        start,
    output logic        busy,
    input  logic [9:0]  element_index,
    input  logic [9:0]  forced_index,
    input  logic [31:0] base_value,
    input  logic [31:0] best_value,
    input  logic [31:0] first_minus,
    input  logic [31:0] first_plus,
    input  logic [31:0] second_minus,
    input  logic [31:0] second_plus,
    input  logic [15:0] cross_draw,
    input  logic [15:0] repair_draw,
    input  logic        last_in,

    output logic        done,
    output logic [31:0] child_value,
    output logic        was_crossed,
    output logic        was_repaired,
    output logic        last_out
);
    import demx_pkg::*;

`include "de_mutate_crossover_element_defines.svh"

    // A forced index at or above the vector length never matches.
    localparam logic [16:0] ForcedLimit = 17'(MAX_ELEMENTS);

    cfg_t cfg;

    demx_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The pipeline never stalls, so an item is accepted whenever start is high.
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // ------------------------------------------------------------------
    // Stage 1: difference vector, bound distances and the crossover decision.
    // ------------------------------------------------------------------
    logic [32:0] diff_first;
    logic [32:0] diff_second;
    logic [33:0] diff_sum;
    logic [32:0] dist_lower;
    logic [32:0] dist_upper;
    logic        forced_hit;
    logic        draw_below;
    logic        crossed_next;

    always_comb
    begin
        diff_first = {first_plus[31], first_plus} - {first_minus[31], first_minus};
        case (cfg.strategy_mode)
            MODE_RAND2: diff_second = {second_plus[31], second_plus}
                                      - {second_minus[31], second_minus};
            MODE_BEST1: diff_second = {best_value[31], best_value}
                                      - {base_value[31], base_value};
            default:    diff_second = '0;
        endcase
        diff_sum   = {diff_first[32], diff_first} + {diff_second[32], diff_second};
        dist_lower = {base_value[31], base_value} - {cfg.lower_bound[31], cfg.lower_bound};
        dist_upper = {cfg.upper_bound[31], cfg.upper_bound} - {base_value[31], base_value};
        forced_hit = ({7'b0, forced_index} < ForcedLimit) && (element_index == forced_index);
        draw_below = {1'b0, cross_draw} < cfg.crossover_rate;
        crossed_next = draw_below || forced_hit;
    end

    logic        s1_valid_reg;
    logic [33:0] s1_diff_reg;
    logic [32:0] s1_dist_lower_reg;
    logic [32:0] s1_dist_upper_reg;
    logic [31:0] s1_base_reg;
    logic [15:0] s1_rdraw_reg;
    logic        s1_crossed_reg;
    logic        s1_last_reg;

    // ------------------------------------------------------------------
    // Stage 2: the three products, each registered on its own.
    // ------------------------------------------------------------------
    logic signed [52:0] prod_scale_next;
    logic signed [49:0] prod_lower_next;
    logic signed [49:0] prod_upper_next;

    always_comb
    begin
        prod_scale_next = $signed({1'b0, cfg.scale_factor}) * $signed(s1_diff_reg);
        prod_lower_next = $signed({1'b0, s1_rdraw_reg}) * $signed(s1_dist_lower_reg);
        prod_upper_next = $signed({1'b0, s1_rdraw_reg}) * $signed(s1_dist_upper_reg);
    end

    logic        s2_valid_reg;
    logic [52:0] s2_prod_scale_reg;
    logic [49:0] s2_prod_lower_reg;
    logic [49:0] s2_prod_upper_reg;
    logic [31:0] s2_base_reg;
    logic        s2_crossed_reg;
    logic        s2_last_reg;

    // ------------------------------------------------------------------
    // Stage 3: mutant value, crossover select and the lower-bound repair.
    // Dropping the low sixteen product bits floors the division by 65536.
    // ------------------------------------------------------------------
    logic [37:0] mutant_value;
    logic [37:0] chosen_value;
    logic [37:0] lower_ext;
    logic [37:0] lower_fixed;
    logic        lower_hit;
    logic [37:0] after_lower_next;

    always_comb
    begin
        mutant_value = {s2_prod_scale_reg[52], s2_prod_scale_reg[52:16]}
                       + {{6{s2_base_reg[31]}}, s2_base_reg};
        chosen_value = s2_crossed_reg ? mutant_value : {{6{s2_base_reg[31]}}, s2_base_reg};
        lower_ext    = {{6{cfg.lower_bound[31]}}, cfg.lower_bound};
        lower_fixed  = lower_ext + {{4{s2_prod_lower_reg[49]}}, s2_prod_lower_reg[49:16]};
        lower_hit    = $signed(chosen_value) < $signed(lower_ext);
        after_lower_next = lower_hit ? lower_fixed : chosen_value;
    end

    logic        s3_valid_reg;
    logic [37:0] s3_value_reg;
    logic [49:0] s3_prod_upper_reg;
    logic        s3_lower_hit_reg;
    logic        s3_crossed_reg;
    logic        s3_last_reg;

    // ------------------------------------------------------------------
    // Stage 4: upper-bound repair into the output register. The repaired
    // value always fits in 32 signed bits, so the low word is the result.
    // ------------------------------------------------------------------
    logic [37:0] upper_ext;
    logic [37:0] upper_fixed;
    logic        upper_hit;
    logic [37:0] final_value;

    always_comb
    begin
        upper_ext   = {{6{cfg.upper_bound[31]}}, cfg.upper_bound};
        upper_fixed = upper_ext - {{4{s3_prod_upper_reg[49]}}, s3_prod_upper_reg[49:16]};
        upper_hit   = $signed(s3_value_reg) > $signed(upper_ext);
        final_value = upper_hit ? upper_fixed : s3_value_reg;
    end

    logic        done_reg;
    logic [31:0] child_value_reg;
    logic        was_crossed_reg;
    logic        was_repaired_reg;
    logic        last_out_reg;

    // Valid bits travel with the data and are the only pipeline state that reset clears.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            done_reg     <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_diff_reg       <= diff_sum;
        s1_dist_lower_reg <= dist_lower;
        s1_dist_upper_reg <= dist_upper;
        s1_base_reg       <= base_value;
        s1_rdraw_reg      <= repair_draw;
        s1_crossed_reg    <= crossed_next;
        s1_last_reg       <= last_in;

        s2_prod_scale_reg <= prod_scale_next;
        s2_prod_lower_reg <= prod_lower_next;
        s2_prod_upper_reg <= prod_upper_next;
        s2_base_reg       <= s1_base_reg;
        s2_crossed_reg    <= s1_crossed_reg;
        s2_last_reg       <= s1_last_reg;

        s3_value_reg      <= after_lower_next;
        s3_prod_upper_reg <= s2_prod_upper_reg;
        s3_lower_hit_reg  <= lower_hit;
        s3_crossed_reg    <= s2_crossed_reg;
        s3_last_reg       <= s2_last_reg;

        child_value_reg   <= final_value[31:0];
        was_crossed_reg   <= s3_crossed_reg;
        was_repaired_reg  <= s3_lower_hit_reg || upper_hit;
        last_out_reg      <= s3_last_reg;
    end

    assign done         = done_reg;
    assign child_value  = child_value_reg;
    assign was_crossed  = was_crossed_reg;
    assign was_repaired = was_repaired_reg;
    assign last_out     = last_out_reg;

    // Every accepted item must come out on the result ports with done high.
    `DMX_ASSERT_DELAY(a_fixed_latency, accept, 4, done)

    // A draw below the crossover rate must come out as a crossed element.
    `DMX_ASSERT_DELAY(a_draw_crosses, accept && draw_below, 4, done && was_crossed)

    // A lower-bound repair in stage three must be reported on the output.
    `DMX_ASSERT_NEXT(a_lower_reported, s3_valid_reg && s3_lower_hit_reg, done && was_repaired)

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the differential evolution mutation, crossover and repair element.
`timescale 1ns / 1ps

module testbench;
    import demx_pkg::*;

    // The package names only the three defined strategies and the five registers.
    // The unused strategy code and the indexes past the register list are exercised
    // too, so they get names of their own here.
    localparam logic [1:0]           MODE_SPARE     = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

    // The block has four register stages between a transfer in and its result.
    localparam int unsigned PIPE_DEPTH      = 4;
    localparam int unsigned PHASES          = 16;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned PRINT_LIMIT     = 100;

    typedef struct {
        logic [INDEX_W-1:0]        element_index;
        logic [INDEX_W-1:0]        forced_index;
        logic signed [VALUE_W-1:0] base_value;
        logic signed [VALUE_W-1:0] best_value;
        logic signed [VALUE_W-1:0] first_minus;
        logic signed [VALUE_W-1:0] first_plus;
        logic signed [VALUE_W-1:0] second_minus;
        logic signed [VALUE_W-1:0] second_plus;
        logic [DRAW_W-1:0]         cross_draw;
        logic [DRAW_W-1:0]         repair_draw;
        logic                      last_in;
    } element_t;

    typedef struct {
        logic [VALUE_W-1:0] child_value;
        logic               crossed;
        logic               repaired;
        logic               last;
    } child_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               start;
    logic               busy;
    logic [9:0]         element_index;
    logic [9:0]         forced_index;
    logic [31:0]        base_value;
    logic [31:0]        best_value;
    logic [31:0]        first_minus;
    logic [31:0]        first_plus;
    logic [31:0]        second_minus;
    logic [31:0]        second_plus;
    logic [15:0]        cross_draw;
    logic [15:0]        repair_draw;
    logic               last_in;
    logic               done;
    logic [31:0]        child_value;
    logic               was_crossed;
    logic               was_repaired;
    logic               last_out;

    // Shadow copy of the configuration registers, updated on every write.
    cfg_t   shadow_cfg;
    // Trial elements that have been predicted but not yet seen on the result ports.
    child_t pending_children[$];

    int  error_count;
    int  sent_count;
    int  checked_count;
    int  write_count;
    int  crossed_count;
    int  repaired_count;
    // When set, the sender offers items back to back with no idle cycles.
    bit  no_gaps;

    de_mutate_crossover_element u_top (.*);

    always #1 clk = ~clk;

    // Hard limit on the run. The slowest correct run takes about 32 us,
    // so this leaves more than ten times that.
    initial
    begin
        #400_000;
        $display("Run did not complete in the allotted time.");
        $display("TB_ERROR");
        $finish;
    end

    task automatic report(input string msg);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    // Computes the trial element for one item under the current shadow settings.
    // All arithmetic is done on 64-bit signed values, so nothing can overflow:
    // the largest product is about 2^51. An arithmetic right shift by 16 on a
    // signed value is exactly floor division by 65536.
    function automatic child_t predict_child(element_t e);
        longint base;
        longint delta;
        longint v;
        longint lo;
        longint hi;
        longint r;
        longint sf;
        child_t c;
        base  = e.base_value;
        lo    = $signed(shadow_cfg.lower_bound);
        hi    = $signed(shadow_cfg.upper_bound);
        r     = e.repair_draw;
        sf    = shadow_cfg.scale_factor;
        delta = longint'(e.first_plus) - longint'(e.first_minus);
        case (shadow_cfg.strategy_mode)
            MODE_RAND2: delta += longint'(e.second_plus) - longint'(e.second_minus);
            MODE_BEST1: delta += longint'(e.best_value) - base;
            default: ;  // rand/1, and the unused code falls back to it
        endcase
        c.crossed = (e.cross_draw < shadow_cfg.crossover_rate) ||
                    (e.forced_index < MAX_ELEMENTS && e.element_index == e.forced_index);
        v = c.crossed ? base + ((sf * delta) >>> 16) : base;
        c.repaired = 1'b0;
        // The lower repair goes first; the upper one then looks at its output, so
        // crossed bounds or a base outside the window can trigger both.
        if (v < lo)
        begin
            v = lo + ((r * (base - lo)) >>> 16);
            c.repaired = 1'b1;
        end
        if (v > hi)
        begin
            v = hi - ((r * (hi - base)) >>> 16);
            c.repaired = 1'b1;
        end
        c.child_value = v[31:0];
        c.last = e.last_in;
        return c;
    endfunction

    // Holds the sender off until every predicted result has been checked.
    task automatic drain_children();
        start <= 1'b0;
        while (pending_children.size() != 0)
            @(posedge clk);
    endtask

    // Register writes happen only with the pipeline empty. Each write pulses the
    // enable high and then waits with it low before it returns.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        drain_children();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        write_count++;
        case (idx)
            REG_STRATEGY: shadow_cfg.strategy_mode  = data[1:0];
            REG_SCALE:    shadow_cfg.scale_factor   = data[SCALE_W-1:0];
            REG_RATE:     shadow_cfg.crossover_rate = data[RATE_W-1:0];
            REG_LOWER:    shadow_cfg.lower_bound    = data;
            REG_UPPER:    shadow_cfg.upper_bound    = data;
            default: ;  // indexes past the register list are ignored
        endcase
        @(posedge clk);
    endtask

    // Fills the bits above a narrow register with random junk that must be dropped.
    function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w);
        return ($urandom() << w) | v;
    endfunction

    // Offers one item after a random idle gap (none when no_gaps is set) and waits
    // for the transfer. The start strobe is left high on return so that the next
    // call can follow without a dead cycle.
    task automatic send_element(input element_t e);
        int     gap;
        child_t c;
        gap = no_gaps ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start         <= 1'b1;
        element_index <= e.element_index;
        forced_index  <= e.forced_index;
        base_value    <= e.base_value;
        best_value    <= e.best_value;
        first_minus   <= e.first_minus;
        first_plus    <= e.first_plus;
        second_minus  <= e.second_minus;
        second_plus   <= e.second_plus;
        cross_draw    <= e.cross_draw;
        repair_draw   <= e.repair_draw;
        last_in       <= e.last_in;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        c = predict_child(e);
        pending_children.push_back(c);
        sent_count++;
        crossed_count  += c.crossed;
        repaired_count += c.repaired;
    endtask

    function automatic element_t make_element(
        logic [9:0] idx, logic [9:0] forced,
        logic [31:0] base, logic [31:0] best,
        logic [31:0] fm, logic [31:0] fp, logic [31:0] sm, logic [31:0] sp,
        logic [15:0] cd, logic [15:0] rd, logic last);
        element_t e;
        e.element_index = idx;
        e.forced_index  = forced;
        e.base_value    = base;
        e.best_value    = best;
        e.first_minus   = fm;
        e.first_plus    = fp;
        e.second_minus  = sm;
        e.second_plus   = sp;
        e.cross_draw    = cd;
        e.repair_draw   = rd;
        e.last_in       = last;
        return e;
    endfunction

    // A value for one operand: fully random, small, close to one of the bounds,
    // or one of the two 32-bit extremes, zero or minus one.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom_range(0, 524287) - 32'd262144;
            2:
            begin
                if ($urandom_range(0, 1) != 0)
                    return shadow_cfg.lower_bound + $urandom_range(0, 131071) - 32'd65536;
                return shadow_cfg.upper_bound + $urandom_range(0, 131071) - 32'd65536;
            end
            default:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
        endcase
    endfunction

    // Out of reset the registers must hold their documented defaults: rand/1,
    // F = 0.5, CR just below 0.9 and a window of -1.0 to +1.0. Two of the draws
    // sit right at the crossover threshold.
    task automatic test_reset_values();
        send_element(make_element(10'd3, 10'd5, 32'h0, 32'h0, 32'h0, 32'h8000, 32'h0, 32'h0,
                                  16'd0, 16'd0, 1'b0));
        send_element(make_element(10'd3, 10'd5, 32'h4000, 32'h0, 32'h8000, 32'h0, 32'h0,
                                  32'h0, RESET_RATE[DRAW_W-1:0] - 1'b1, 16'h1234, 1'b0));
        send_element(make_element(10'd3, 10'd5, 32'h4000, 32'h0, 32'h8000, 32'h0, 32'h0,
                                  32'h0, RESET_RATE[DRAW_W-1:0], 16'h1234, 1'b0));
        // A draw that fails the test, but the element is at the forced position.
        send_element(make_element(10'd5, 10'd5, 32'hFFFF_C000, 32'h0, 32'h0, 32'h8000, 32'h0,
                                  32'h0, 16'hFFFF, 16'h1234, 1'b1));
    endtask

    // Every strategy including the unused code, writes to indexes past the list,
    // junk above narrow registers, and each repair path on its own and combined.
    task automatic test_modes_and_repairs();
        logic [1:0] modes[4];
        modes = '{MODE_RAND1, MODE_RAND2, MODE_BEST1, MODE_SPARE};
        write_reg(REG_RATE, with_junk(32'd65536, RATE_W));
        write_reg(REG_SPARE_LOW, $urandom());
        write_reg(REG_SPARE_HIGH, $urandom());
        foreach (modes[i])
        begin
            write_reg(REG_STRATEGY, with_junk(modes[i], 2));
            send_element(make_element(10'd1, 10'd700, 32'h1000, 32'h3000, 32'h0100, 32'h0900,
                                      32'h0200, 32'h0700, 16'hFFFF, 16'h8000, 1'b0));
        end
        write_reg(REG_STRATEGY, with_junk(MODE_RAND1, 2));
        // Mutant far below the window, then far above it.
        send_element(make_element(10'd2, 10'd2, 32'hFFFF_8000, 32'h0, 32'h0, 32'h8000_0000,
                                  32'h0, 32'h0, 16'd0, 16'h8000, 1'b0));
        send_element(make_element(10'd2, 10'd2, 32'h0000_8000, 32'h0, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0, 32'h0, 16'd0, 16'hC000, 1'b0));
        // With CR at zero only the forced position crosses. A copied base that lies
        // outside the window is still repaired.
        write_reg(REG_RATE, with_junk(32'd0, RATE_W));
        send_element(make_element(10'd4, 10'd9, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h10000,
                                  32'h0, 32'h0, 16'd0, 16'hFFFF, 1'b0));
        send_element(make_element(10'd4, 10'd9, 32'h8000_0000, 32'h0, 32'h0, 32'h10000,
                                  32'h0, 32'h0, 16'd0, 16'hFFFF, 1'b0));
        send_element(make_element(10'd9, 10'd9, 32'h0, 32'h0, 32'h0, 32'h10000,
                                  32'h0, 32'h0, 16'hFFFF, 16'h4000, 1'b1));
        // Crossed bounds: the lower repair lifts the value above the upper bound,
        // so the upper repair applies right after it.
        write_reg(REG_LOWER, 32'h0001_0000);
        write_reg(REG_UPPER, 32'hFFFF_0000);
        send_element(make_element(10'd0, 10'd1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0,
                                  16'hFFFF, 16'h4000, 1'b0));
        // A zero scale factor makes the mutant equal to the base.
        write_reg(REG_LOWER, RESET_LOWER);
        write_reg(REG_UPPER, RESET_UPPER);
        write_reg(REG_SCALE, with_junk(32'd0, SCALE_W));
        write_reg(REG_RATE, with_junk(32'd65536, RATE_W));
        send_element(make_element(10'd6, 10'd7, 32'h0000_2000, 32'h0, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h0, 32'h0, 16'h0, 16'h0, 1'b0));
    endtask

    // A scale factor of 2.0 and the full 32-bit window, with every operand at its
    // extremes. The internal sums must not wrap.
    task automatic test_field_extremes();
        write_reg(REG_SCALE, with_junk(32'd131072, SCALE_W));
        write_reg(REG_LOWER, 32'h8000_0000);
        write_reg(REG_UPPER, 32'h7FFF_FFFF);
        write_reg(REG_STRATEGY, with_junk(MODE_RAND2, 2));
        send_element(make_element(10'd0, 10'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  16'd0, 16'd0, 1'b0));
        send_element(make_element(10'd1023, 10'd1023, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                  16'hFFFF, 16'hFFFF, 1'b1));
        send_element(make_element(10'd0, 10'd1023, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                  16'd0, 16'hFFFF, 1'b0));
        send_element(make_element(10'd1023, 10'd0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                  16'd0, 16'hFFFF, 1'b1));
        write_reg(REG_STRATEGY, with_junk(MODE_BEST1, 2));
        send_element(make_element(10'd512, 10'd512, 32'h8000_0000, 32'h7FFF_FFFF,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0,
                                  16'hFFFF, 16'h8000, 1'b0));
    endtask

    // New register values for one random phase. The first three phases pin the
    // extremes; the rest draw from a mix of extremes and random values.
    task automatic choose_settings(input int phase);
        logic [1:0]  mode;
        logic [31:0] scale;
        logic [31:0] rate;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] tmp;
        case (phase)
            0:
            begin
                mode = MODE_RAND1;
                scale = 0;
                rate = 0;
                lo = 32'h8000_0000;
                hi = 32'h7FFF_FFFF;
            end
            1:
            begin
                mode = MODE_SPARE;
                scale = 131072;
                rate = 65536;
                lo = 32'h0;
                hi = 32'h0;
            end
            2:
            begin
                mode = MODE_BEST1;
                scale = 131072;
                rate = 65536;
                lo = 32'h7FFF_FFFF;
                hi = 32'h8000_0000;
            end
            default:
            begin
                mode = 2'($urandom_range(0, 3));
                case ($urandom_range(0, 4))
                    0: scale = 0;
                    1: scale = 131072;
                    default: scale = $urandom_range(0, 131072);
                endcase
                case ($urandom_range(0, 4))
                    0: rate = 0;
                    1: rate = 65536;
                    default: rate = $urandom_range(0, 65536);
                endcase
                case ($urandom_range(0, 3))
                    0:
                    begin
                        // A narrow window around a small value, the usual case.
                        lo = $urandom_range(0, 524287) - 32'd262144;
                        hi = lo + $urandom_range(0, 1048576);
                    end
                    1:
                    begin
                        lo = $urandom();
                        hi = $urandom();
                        if ($signed(lo) > $signed(hi))
                        begin
                            tmp = lo;
                            lo = hi;
                            hi = tmp;
                        end
                    end
                    2:
                    begin
                        lo = 32'h8000_0000;
                        hi = 32'h7FFF_FFFF;
                    end
                    default:
                    begin
                        // Crossed bounds.
                        hi = $urandom_range(0, 524287) - 32'd262144;
                        lo = hi + $urandom_range(1, 262144);
                    end
                endcase
            end
        endcase
        write_reg(REG_STRATEGY, with_junk(mode, 2));
        write_reg(REG_SCALE, with_junk(scale, SCALE_W));
        write_reg(REG_RATE, with_junk(rate, RATE_W));
        write_reg(REG_LOWER, lo);
        write_reg(REG_UPPER, hi);
    endtask

    // Most traffic is whole vectors: consecutive element positions, one forced
    // position for the vector and last_in on its final element. A few stray items
    // with every field random are mixed in between vectors.
    task automatic test_random_phases();
        element_t e;
        int       len;
        int       first;
        int       forced;
        int       in_phase;
        bit       paused;
        paused = 1'b0;
        for (int p = 0; p < PHASES; p++)
        begin
            choose_settings(p);
            no_gaps = ($urandom_range(0, 3) == 0);
            in_phase = 0;
            while (in_phase < ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    e = make_element(10'($urandom()), 10'($urandom()), $urandom(),
                                     $urandom(), $urandom(), $urandom(), $urandom(),
                                     $urandom(), 16'($urandom()), 16'($urandom()),
                                     1'($urandom()));
                    send_element(e);
                    in_phase++;
                end
                else
                begin
                    len = $urandom_range(1, 16);
                    first = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 1024 - len);
                    if ($urandom_range(0, 3) != 0)
                        forced = first + $urandom_range(0, len - 1);
                    else
                        forced = $urandom_range(0, 1023);
                    for (int k = 0; k < len; k++)
                    begin
                        e = make_element(10'(first + k), 10'(forced), pick_value(),
                                         pick_value(), pick_value(), pick_value(),
                                         pick_value(), pick_value(), 16'($urandom()),
                                         16'($urandom()), k == len - 1);
                        send_element(e);
                        in_phase++;
                    end
                end
                // Once, in the middle of a phase, let the pipeline run dry before
                // the next item goes in.
                if (p == 4 && !paused && in_phase >= ITEMS_PER_PHASE / 2)
                begin
                    drain_children();
                    paused = 1'b1;
                end
            end
        end
    endtask

    // Result checker. A result is on the ports for exactly one cycle, so it is
    // taken at the edge that ends that cycle. Outputs read right after the edge
    // still hold their values from before it.
    always @(posedge clk)
    begin
        child_t want;
        if (rst_n && done)
        begin
            if (pending_children.size() == 0)
                report($sformatf("result %h arrived with nothing outstanding", child_value));
            else
            begin
                want = pending_children.pop_front();
                checked_count++;
                if (child_value !== want.child_value)
                    report($sformatf("child_value got %h expected %h",
                                     child_value, want.child_value));
                if (was_crossed !== want.crossed)
                    report($sformatf("was_crossed got %b expected %b",
                                     was_crossed, want.crossed));
                if (was_repaired !== want.repaired)
                    report($sformatf("was_repaired got %b expected %b",
                                     was_repaired, want.repaired));
                if (last_out !== want.last)
                    report($sformatf("last_out got %b expected %b", last_out, want.last));
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = REG_STRATEGY;
        cfg_data      = '0;
        start         = 1'b0;
        element_index = '0;
        forced_index  = '0;
        base_value    = '0;
        best_value    = '0;
        first_minus   = '0;
        first_plus    = '0;
        second_minus  = '0;
        second_plus   = '0;
        cross_draw    = '0;
        repair_draw   = '0;
        last_in       = 1'b0;
        no_gaps       = 1'b0;

        shadow_cfg.strategy_mode  = RESET_STRATEGY;
        shadow_cfg.scale_factor   = RESET_SCALE;
        shadow_cfg.crossover_rate = RESET_RATE;
        shadow_cfg.lower_bound    = RESET_LOWER;
        shadow_cfg.upper_bound    = RESET_UPPER;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_modes_and_repairs();
        test_field_extremes();
        test_random_phases();

        // Every transfer in must come out; the clock then runs on past the pipeline depth
        // to catch any extra result.
        drain_children();
        repeat (PIPE_DEPTH + 4) @(posedge clk);

        $display("Sent %0d elements over %0d register writes, including all strategies,",
                 sent_count, write_count);
        $display("extreme settings and crossed bounds: %0d crossed, %0d repaired, %0d checked.",
                 crossed_count, repaired_count, checked_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/demx_pkg.sv
hdl/demx_cfg_regs.sv
hdl/de_mutate_crossover_element.sv
verif/testbench.sv
